### rtl/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg
// shared types and constants of the gray 2x2 box downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package gbd_pkg;

  // field and register widths
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned GRAY_W   = 8;
  localparam int unsigned SRC_W_W  = 13;
  localparam int unsigned OUT_W_W  = 11;
  localparam int unsigned OUT_H_W  = 12;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned BX_W     = 11;
  localparam int unsigned WSUM_W   = 15;
  localparam int unsigned PAIR_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 2'd2;

  // register reset values
  localparam logic [SRC_W_W-1:0] SOURCE_WIDTH_RST = 13'd640;
  localparam logic [OUT_W_W-1:0] OUT_WIDTH_RST    = 11'd320;
  localparam logic [OUT_H_W-1:0] OUT_HEIGHT_RST   = 12'd200;

  // luma weights in hundredths, and x/100 as x*5243>>19 (exact below 25600)
  localparam int unsigned LUMA_WR      = 30;
  localparam int unsigned LUMA_WG      = 59;
  localparam int unsigned LUMA_WB      = 11;
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [SRC_W_W-1:0] source_width;
    logic [OUT_W_W-1:0] out_width;
    logic [OUT_H_W-1:0] out_height;
  } gbd_cfg_t;

  // one in-region pixel handed from front to back
  typedef struct packed {
    logic              odd;        // right pixel of a column pair
    logic              lower;      // lower row of a block
    logic              frame_end;  // last block of the frame
    logic [BX_W-1:0]   bx;         // block column
    logic [WSUM_W-1:0] wsum;       // 30r+59g+11b
  } gbd_entry_t;

endpackage

`default_nettype wire

### rtl/gbd_if.sv
// ----------------------------------------------------------------------------
// gbd_if
// valid/ready stream interfaces for source pixels and gray results
// ----------------------------------------------------------------------------
`default_nettype none

interface gbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface gbd_gray_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       frame_end;

  modport source (output valid, gray, frame_end, input ready);
  modport sink   (input valid, gray, frame_end, output ready);
endinterface

`default_nettype wire

### rtl/gbd_ram.sv
// ----------------------------------------------------------------------------
// gbd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/gbd_queue.sv
// ----------------------------------------------------------------------------
// gbd_queue
// short fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire gbd_pkg::gbd_entry_t push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output gbd_pkg::gbd_entry_t      pop_data_o,
  output logic                     empty_o
);
  import gbd_pkg::*;

  gbd_entry_t        slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gbd_front.sv
// ----------------------------------------------------------------------------
// gbd_front
// pixel intake: raster counters, region check and weighted color sum
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_front #(
  parameter int unsigned MAX_OUT_WIDTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gbd_pkg::gbd_cfg_t   cfg_i,
  gbd_pix_if.sink                  pix_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output gbd_pkg::gbd_entry_t      q_data_o
);
  import gbd_pkg::*;

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] col_cur, row_cur;
  logic [BX_W-1:0]  bx, by;
  logic             accept, in_region, row_end;

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    col_cur   = pix_i.frame_start ? '0 : col_q;
    row_cur   = pix_i.frame_start ? '0 : row_q;
    bx        = col_cur[CNT_W-1:1];
    by        = row_cur[CNT_W-1:1];
    in_region = (bx < cfg_i.out_width)
             && ({1'b0, by} < cfg_i.out_height)
             && (SRC_W_W'(bx) < SRC_W_W'(MAX_OUT_WIDTH));
    row_end   = ((SRC_W_W'(col_cur) + 1'b1) >= cfg_i.source_width)
             || (col_cur == '1);

    col_d = row_end ? '0 : col_cur + 1'b1;
    row_d = row_end ? row_cur + 1'b1 : row_cur;

    q_data_o.odd       = col_cur[0];
    q_data_o.lower     = row_cur[0];
    q_data_o.frame_end = ((OUT_H_W'(bx) + 1'b1) == OUT_H_W'(cfg_i.out_width))
                      && ((OUT_H_W'(by) + 1'b1) == cfg_i.out_height);
    q_data_o.bx        = bx;
    q_data_o.wsum      = WSUM_W'(LUMA_WR * pix_i.red + LUMA_WG * pix_i.green
                                 + LUMA_WB * pix_i.blue);
    q_push_o           = accept && in_region;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

### rtl/gbd_back.sv
// ----------------------------------------------------------------------------
// gbd_back
// luma, pair sums, line store access and the gray output register
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_back #(
  parameter int unsigned MAX_OUT_WIDTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire gbd_pkg::gbd_entry_t q_data_i,
  output logic                     q_pop_o,
  gbd_gray_if.source               gray_o
);
  import gbd_pkg::*;

  localparam int unsigned AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned XW = (AW > BX_W) ? AW : BX_W;

  gbd_entry_t        a_ent_q;
  logic              a_vld_q;
  logic [PAIR_W-1:0] pair_q, pair_new;
  logic [PAIR_W-1:0] upper_sum;
  logic [GRAY_W-1:0] luma;
  logic [PAIR_W:0]   total;
  logic              emit, advance, a_fire;
  logic              out_vld_q;
  logic [GRAY_W-1:0] gray_q;
  logic              fe_q;
  logic [XW-1:0]     rd_ext, wr_ext;
  logic [31:0]       prod;

  always_comb begin
    prod     = 32'(a_ent_q.wsum) * DIV100_MUL;
    luma     = GRAY_W'(prod >> DIV100_SHIFT);
    pair_new = a_ent_q.odd ? pair_q + PAIR_W'(luma) : PAIR_W'(luma);
    total    = {1'b0, upper_sum} + {1'b0, pair_new};
    emit     = a_ent_q.odd && a_ent_q.lower;
    advance  = !out_vld_q || gray_o.ready;
    a_fire   = a_vld_q && (!emit || advance);
    q_pop_o  = !q_empty_i && (!a_vld_q || a_fire);
    rd_ext   = XW'(q_data_i.bx);
    wr_ext   = XW'(a_ent_q.bx);
  end

  gbd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (a_fire && a_ent_q.odd && !a_ent_q.lower),
    .waddr_i (wr_ext[AW-1:0]),
    .wdata_i (pair_new),
    .re_i    (q_pop_o),
    .raddr_i (rd_ext[AW-1:0]),
    .rdata_o (upper_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        a_vld_q <= 1'b1;
      end else if (a_fire) begin
        a_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= a_fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_ent_q <= q_data_i;
    end
    if (a_fire) begin
      pair_q <= pair_new;
    end
    if (a_fire && emit) begin
      gray_q <= total[PAIR_W:2];
      fe_q   <= a_ent_q.frame_end;
    end
  end

  assign gray_o.valid     = out_vld_q;
  assign gray_o.gray      = gray_q;
  assign gray_o.frame_end = fe_q;

endmodule

`default_nettype wire

### rtl/gray_2x2_box_downscale.sv
// ----------------------------------------------------------------------------
// gray_2x2_box_downscale
// rgb to gray 2x2 box downsample; unless gray_o stalls, one pixel per clock
// ----------------------------------------------------------------------------
// Raster-order RGB pixels come in on pix_i, one transaction per pixel, and
// one gray byte leaves on gray_o for every 2x2 block of the top-left
// 2*out_width by 2*out_height region, at the block's bottom-right pixel; all
// other pixels are swallowed. Unless gray_o stalls, the block sustains one
// pixel per clock: the front stage classifies each pixel as it is taken, a
// four-entry queue parts it from the back stage, and the back stage retires
// one queued pixel per clock through a single line store with one write and
// one read port. Each result is registered behind the queue and a_ent_q;
// pix_i.ready drops only once the queue has filled behind a stalled gray_o.
// The line store has no clearing pass, so the block takes pixels right after
// reset. The user writes configuration through cfg_we_i / cfg_idx_i /
// cfg_data_i only while no pixel is in flight, unenforced by the block.
`default_nettype none

module gray_2x2_box_downscale #(
  parameter int unsigned MAX_OUT_WIDTH = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  gbd_pix_if.sink                              pix_i,
  gbd_gray_if.source                           gray_o
);
  import gbd_pkg::*;

  // configuration registers
  gbd_cfg_t   cfg_q;

  // front to queue
  logic       q_push;
  gbd_entry_t q_wdata;
  logic       q_full;

  // queue to back
  logic       q_pop;
  gbd_entry_t q_rdata;
  logic       q_empty;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width <= SOURCE_WIDTH_RST;
      cfg_q.out_width    <= OUT_WIDTH_RST;
      cfg_q.out_height   <= OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_WIDTH: cfg_q.source_width <= cfg_data_i;
        CFG_OUT_WIDTH:    cfg_q.out_width    <= cfg_data_i[OUT_W_W-1:0];
        CFG_OUT_HEIGHT:   cfg_q.out_height   <= cfg_data_i[OUT_H_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster counters and region check, pushes only in-region pixels
  gbd_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // decouples intake from a stalled output
  gbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  // luma, pair sums against the line store, gray output register
  gbd_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .gray_o    (gray_o)
  );

endmodule

`default_nettype wire

### rtl/gbd_checker.sv
// ----------------------------------------------------------------------------
// gbd_checker
// port-level assertions for the gray downscaler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] gray_i,
  input wire logic       frame_end_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(gray_i) && $stable(frame_end_i)))
    else $error("stalled result changed");

  // intake backs up only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input ready dropped without output stall");

  // a cycle with the output ready frees room for a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_ready_i) |-> in_ready_i)
    else $error("input not ready after output was ready");

  // ready is never withheld while idle right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_i && !out_valid_i)
    else $error("block not idle after reset");

endmodule

bind gray_2x2_box_downscale gbd_checker u_gbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (gray_o.valid),
  .out_ready_i (gray_o.ready),
  .gray_i      (gray_o.gray),
  .frame_end_i (gray_o.frame_end)
);

`default_nettype wire

### sim/gray_2x2_box_downscale_test.sv
// ----------------------------------------------------------------------------
// gray_2x2_box_downscale_test
// self-checking bench for the rgb to gray 2x2 box downscaler
// ----------------------------------------------------------------------------
// Pixels go in through a queue-fed driver, and every pixel the block takes is
// run through a bench-side model of the downscaler at the same clock edge.
// Each gray transaction that leaves the block is checked, field by field,
// against the oldest outstanding prediction. The run walks through directed
// frames, corner geometries (one-pixel rows, empty regions, narrow source)
// and random small frames, under changing amounts of idling on both sides.
// ----------------------------------------------------------------------------

module gray_2x2_box_downscale_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbd_pkg::*;

  localparam int unsigned STORE_DEPTH  = 1024;    // line store entries in the dut
  localparam int unsigned HOLD_CYCLES  = 300;     // long receiver stall
  localparam int unsigned TAIL_CYCLES  = 12;      // latency plus queue depth, with margin
  localparam int unsigned ITEM_BUDGET  = 750;     // input pixel budget; the random phases stop once it is reached
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              frame_end;
  } gray_result_t;

  // clock, reset and configuration port
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gbd_pix_if  pix_if ();
  gbd_gray_if gray_if ();

  gray_2x2_box_downscale #(
    .MAX_OUT_WIDTH(STORE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .gray_o     (gray_if)
  );

  // pixels waiting for the driver, and gray results still owed by the dut
  pixel_t       pixel_q[$];
  gray_result_t expected_gray_q[$];

  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned mismatch_count;
  longint unsigned cycle_count;

  // idling percentages, set by the stimulus process per phase
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  // long receiver stall: the stimulus bumps hold_req, the receiver counts
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  logic   pix_taken;
  pixel_t drive_px;
  gray_result_t want;

  // shadow of the geometry registers
  logic [SRC_W_W-1:0] src_width_cfg;
  logic [OUT_W_W-1:0] out_width_cfg;
  logic [OUT_H_W-1:0] out_height_cfg;

  // shadow of the downscaler state
  logic [CNT_W-1:0]  col_cnt;
  logic [CNT_W-1:0]  row_cnt;
  logic [PAIR_W-1:0] pair_acc;
  logic [PAIR_W-1:0] upper_pairs [STORE_DEPTH];

  // ---------------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d pixels left to send, %0d results outstanding",
               $realtime, pixel_q.size(), expected_gray_q.size());
      $display("FAIL gray_2x2_box_downscale");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction: one accepted pixel, zero or one gray result
  // ---------------------------------------------------------------------------
  function automatic void downscale_pixel(input pixel_t px);
    int unsigned  luma;
    int unsigned  col;
    int unsigned  row;
    int unsigned  bx;
    int unsigned  by;
    int unsigned  total;
    bit           in_region;
    gray_result_t res;

    // frame start puts this pixel at row 0, column 0
    if (px.frame_start) begin
      col_cnt  = '0;
      row_cnt  = '0;
      pair_acc = '0;
    end
    col = col_cnt;
    row = row_cnt;

    // exact integer form of 0.30 r + 0.59 g + 0.11 b, floored
    luma = (30 * int'(px.red) + 59 * int'(px.green) + 11 * int'(px.blue)) / 100;

    if (col % 2 == 0) begin
      pair_acc = luma[PAIR_W-1:0];
    end else begin
      pair_acc = pair_acc + luma[PAIR_W-1:0];
    end

    // block columns past the line store count as outside the region
    bx = col / 2;
    by = row / 2;
    in_region = (bx < out_width_cfg) && (by < out_height_cfg) && (bx < STORE_DEPTH);

    if (in_region && (col % 2 == 1)) begin
      if (row % 2 == 0) begin
        upper_pairs[bx] = pair_acc;
      end else begin
        total         = int'(upper_pairs[bx]) + int'(pair_acc);
        res.gray      = total[GRAY_W+1:2];
        res.frame_end = (bx + 1 == out_width_cfg) && (by + 1 == out_height_cfg);
        expected_gray_q.push_back(res);
      end
    end

    // row end at the last source column, or at the 12-bit column limit
    if (col + 1 >= src_width_cfg || col >= 4095) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      // previous transaction done, offer the next one unless idling
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_px              = pixel_q.pop_front();
        pix_if.valid         <= 1'b1;
        pix_if.red           <= drive_px.red;
        pix_if.green         <= drive_px.green;
        pix_if.blue          <= drive_px.blue;
        pix_if.frame_start   <= drive_px.frame_start;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // gray receiver: random stalls, plus the long hold when requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      gray_if.ready <= 1'b0;
    end else begin
      gray_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: outputs sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_taken <= 1'b0;
    end else begin
      // check the result first: it always belongs to an earlier pixel
      if (gray_if.valid && gray_if.ready) begin
        if (expected_gray_q.size() == 0) begin
          $display("%0t unexpected gray transaction: gray %0d frame_end %0b",
                   $realtime, gray_if.gray, gray_if.frame_end);
          mismatch_count++;
        end else begin
          want = expected_gray_q.pop_front();
          if (gray_if.gray !== want.gray) begin
            $display("%0t gray mismatch: expected %0d actual %0d",
                     $realtime, want.gray, gray_if.gray);
            mismatch_count++;
          end
          if (gray_if.frame_end !== want.frame_end) begin
            $display("%0t frame_end mismatch: expected %0b actual %0b",
                     $realtime, want.frame_end, gray_if.frame_end);
            mismatch_count++;
          end
        end
      end

      pix_taken <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) begin
        pixels_taken++;
        downscale_pixel('{red: pix_if.red, green: pix_if.green, blue: pix_if.blue,
                          frame_start: pix_if.frame_start});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b, input logic fs);
    pixel_q.push_back('{red: r, green: g, blue: b, frame_start: fs});
    pixels_queued++;
  endtask

  // a frame of random pixels; restart_odds > 0 sprinkles stray frame starts
  task automatic push_random_frame(input int unsigned len, input int unsigned restart_odds);
    logic fs;
    for (int unsigned i = 0; i < len; i++) begin
      fs = (i == 0) || (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
      push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), fs);
    end
  endtask

  // wait until every pixel is taken and every result has come, then let the
  // pipeline empty of pixels that make no result
  task automatic settle();
    while (pixels_taken != pixels_queued || expected_gray_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
  endtask

  // new geometry, only with the block idle; the next frame must open with
  // a frame start so no lower row reads a stale line store entry
  task automatic set_geometry(input int unsigned sw, input int unsigned ow,
                              input int unsigned oh);
    settle();
    write_reg(CFG_SOURCE_WIDTH, sw);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    cfg_we_i       <= 1'b0;
    src_width_cfg   = sw[SRC_W_W-1:0];
    out_width_cfg   = ow[OUT_W_W-1:0];
    out_height_cfg  = oh[OUT_H_W-1:0];
  endtask

  // one random phase of small frames
  task automatic random_phase();
    int unsigned sw;
    int unsigned ow;
    int unsigned oh;
    int unsigned kind;
    int unsigned len;

    kind = $urandom_range(15);
    ow   = $urandom_range(1, 6);
    oh   = $urandom_range(1, 4);
    sw   = 2 * ow + $urandom_range(0, 4);
    case (kind)
      0: begin
        sw = $urandom_range(1, 2 * ow - 1);   // narrow source
      end
      1: begin
        ow = 0;
      end
      2: begin
        oh = 0;
      end
      3: begin
        sw = $urandom_range(0, 1);            // every pixel ends its row
      end
      default: begin
      end
    endcase
    set_geometry(sw, ow, oh);

    repeat ($urandom_range(1, 3)) begin
      // full frame, sometimes with a row past the region
      len = (sw < 2 ? 1 : sw) * (2 * (oh == 0 ? 1 : oh) + $urandom_range(0, 1));
      // now and then a broken frame cut short
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, len);
      end
      push_random_frame(len, 60);
    end
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // known values on every input from time zero
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SOURCE_WIDTH;
    cfg_data_i     = '0;
    pix_if.valid       = 1'b0;
    pix_if.red         = '0;
    pix_if.green       = '0;
    pix_if.blue        = '0;
    pix_if.frame_start = 1'b0;
    gray_if.ready  = 1'b0;
    pixels_queued  = 0;
    pixels_taken   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_req       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    src_width_cfg  = SOURCE_WIDTH_RST;
    out_width_cfg  = OUT_WIDTH_RST;
    out_height_cfg = OUT_HEIGHT_RST;
    col_cnt        = '0;
    row_cnt        = '0;
    pair_acc       = '0;
    set_idling(13, 66);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed 4x2 frames: black block and white block, then primaries, secondaries and two odd pixels
    set_geometry(4, 2, 1);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    push_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    // frame start in the middle of a frame restarts the counters
    push_random_frame(3, 0);
    push_random_frame(8, 0);

    // source width of zero and of one: every pixel is a row of its own
    set_geometry(0, 2, 1);
    push_random_frame(6, 0);
    set_geometry(1, 2, 1);
    push_random_frame(6, 0);
    // empty output region in either direction
    set_geometry(4, 0, 1);
    push_random_frame(8, 0);
    set_geometry(4, 2, 0);
    push_random_frame(8, 0);
    // narrow source: the second block column never completes, no frame end
    set_geometry(3, 2, 2);
    push_random_frame(12, 0);

    // long receiver hold while the sender keeps offering pixels
    set_geometry(4, 2, 2);
    hold_req++;
    repeat (3) push_random_frame(16, 0);

    while (pixels_queued < ITEM_BUDGET / 3) random_phase();

    set_idling(66, 13);
    while (pixels_queued < 2 * ITEM_BUDGET / 3) random_phase();

    set_idling(0, 0);
    while (pixels_queued < ITEM_BUDGET) random_phase();

    settle();
    if (mismatch_count == 0) begin
      $display("PASS gray_2x2_box_downscale");
    end else begin
      $display("FAIL gray_2x2_box_downscale");
    end
    $finish;
  end

endmodule
